@@ rtl/core/plb_pkg.sv @@
// Shared types and codes for the positional list buffer.
// Holds the command codes, result status codes and sequencer states.
// No dependencies.
`default_nettype none

package plb_pkg;

    // Command codes carried in the low bits of the input word.
    localparam logic [2:0] CMD_CLEAR  = 3'd0;
    localparam logic [2:0] CMD_INSERT = 3'd1;
    localparam logic [2:0] CMD_DELETE = 3'd2;
    localparam logic [2:0] CMD_SEARCH = 3'd3;
    localparam logic [2:0] CMD_UPDATE = 3'd4;
    localparam logic [2:0] CMD_READ   = 3'd5;

    // Field widths of the input and result words.
    localparam int CMD_W   = 3;
    localparam int POS_W   = 8;
    localparam int DATA_W  = 32;
    localparam int STAT_W  = 3;
    localparam int COUNT_W = 8;

    // Result status returned with every command.
    typedef enum logic [STAT_W-1:0] {
        ST_OK     = 3'd0,
        ST_FULL   = 3'd1,
        ST_EMPTY  = 3'd2,
        ST_BADPOS = 3'd3,
        ST_NOTFND = 3'd4,
        ST_BADCMD = 3'd5
    } status_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_INS,
        S_INS_PUT,
        S_DEL,
        S_SRCH,
        S_RD,
        S_DONE
    } state_t;

endpackage

`default_nettype wire

@@ rtl/core/positional_list_buffer.sv @@
// Positional list buffer: an ordered list of signed 32-bit entries kept in one
// synchronous single-read, single-write memory, with a command sequencer.
// Depends on plb_pkg.
`default_nettype none

// One command word is taken whenever the sequencer is idle, and each command
// gives exactly one result word. The list lives in one memory with a
// registered read, so every multi-entry command walks the memory one entry per
// cycle: insert from the tail down to the one-based position P, delete from P
// up to the tail, search from the head until a match or the end of the list.
// Shifts read one entry ahead of the write, so read and write never meet at
// the same entry. The result register lets the next command be taken while
// the previous result still waits.
module positional_list_buffer #(
    parameter int DEPTH = 128
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // s_tdata: cmd [2:0], position [10:3], data_in [42:11], zero [47:43]
    input  wire logic [47:0] s_tdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // m_tdata: status [2:0], found_position [10:3], data_out [42:11],
    //          count_out [50:43], zero [55:51]
    output logic [55:0]      m_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = ((CNT_W > plb_pkg::POS_W) ? CNT_W : plb_pkg::POS_W) + 1;
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

    // Input word fields.
    logic [plb_pkg::CMD_W-1:0]  cmd_in;
    logic [plb_pkg::POS_W-1:0]  pos_in;
    logic [plb_pkg::DATA_W-1:0] data_in;

    assign cmd_in  = s_tdata[2:0];
    assign pos_in  = s_tdata[10:3];
    assign data_in = s_tdata[42:11];

    // Sequencer and result registers.
    plb_pkg::state_t            state_reg, state_next;
    plb_pkg::status_t           status_reg, status_next;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic [CNT_W-1:0]           idx_reg, idx_next;
    logic [IDX_W-1:0]           pos0_reg, pos0_next;
    logic [plb_pkg::DATA_W-1:0] word_reg, word_next;
    logic                       pend_reg, pend_next;
    logic [IDX_W-1:0]           pend_addr_reg, pend_addr_next;
    logic                       cap_reg, cap_next;
    logic [plb_pkg::POS_W-1:0]  found_reg, found_next;
    logic [plb_pkg::DATA_W-1:0] dout_reg, dout_next;
    logic                       m_valid_reg, m_valid_next;
    logic [55:0]                m_data_reg, m_data_next;

    // Memory ports.
    logic                       wr_en;
    logic [IDX_W-1:0]           wr_addr;
    logic [plb_pkg::DATA_W-1:0] wr_data;
    logic                       rd_en;
    logic [IDX_W-1:0]           rd_addr;
    logic [plb_pkg::DATA_W-1:0] rd_data_reg;
    logic [plb_pkg::DATA_W-1:0] mem [DEPTH];

    // Position checks, done at a width that holds both position and count.
    logic [CMP_W-1:0] pos_ext;
    logic [CMP_W-1:0] cnt_ext;
    logic [CMP_W-1:0] pos_m1;
    logic             list_empty;
    logic             list_full;
    logic             ins_badpos;
    logic             acc_badpos;

    assign pos_ext    = CMP_W'(pos_in);
    assign cnt_ext    = CMP_W'(count_reg);
    assign pos_m1     = pos_ext - CMP_W'(1);
    assign list_empty = (count_reg == '0);
    assign list_full  = (count_reg == DEPTH_CNT);
    assign ins_badpos = (pos_ext == '0) || (pos_ext > cnt_ext + CMP_W'(1));
    assign acc_badpos = (pos_ext == '0) || (pos_ext > cnt_ext);

    assign s_tready = (state_reg == plb_pkg::S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // List memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= plb_pkg::S_IDLE;
            count_reg   <= '0;
            pend_reg    <= 1'b0;
            cap_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            pend_reg    <= pend_next;
            cap_reg     <= cap_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        status_reg    <= status_next;
        idx_reg       <= idx_next;
        pos0_reg      <= pos0_next;
        word_reg      <= word_next;
        pend_addr_reg <= pend_addr_next;
        found_reg     <= found_next;
        dout_reg      <= dout_next;
        m_data_reg    <= m_data_next;
    end

    // Sequencer: next state, memory accesses and result assembly.
    always_comb
    begin
        logic [CNT_W:0]  idx_inc;
        logic [CMP_W-1:0] found_sum;

        state_next     = state_reg;
        status_next    = status_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        pos0_next      = pos0_reg;
        word_next      = word_reg;
        pend_next      = pend_reg;
        pend_addr_next = pend_addr_reg;
        cap_next       = cap_reg;
        found_next     = found_reg;
        dout_next      = dout_reg;
        m_valid_next   = m_valid_reg;
        m_data_next    = m_data_reg;
        wr_en          = 1'b0;
        wr_addr        = pend_addr_reg;
        wr_data        = rd_data_reg;
        rd_en          = 1'b0;
        rd_addr        = idx_reg[IDX_W-1:0];
        idx_inc        = (CNT_W + 1)'(idx_reg) + (CNT_W + 1)'(1);
        found_sum      = CMP_W'(pend_addr_reg) + CMP_W'(1);

        // A waiting result leaves when the sink takes it.
        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            plb_pkg::S_IDLE:
            begin
                if (s_tvalid)
                begin
                    word_next   = data_in;
                    pos0_next   = pos_m1[IDX_W-1:0];
                    found_next  = '0;
                    dout_next   = '0;
                    status_next = plb_pkg::ST_OK;
                    pend_next   = 1'b0;
                    state_next  = plb_pkg::S_DONE;
                    unique case (cmd_in)
                        plb_pkg::CMD_CLEAR:
                        begin
                            count_next = '0;
                        end
                        plb_pkg::CMD_INSERT:
                        begin
                            priority if (list_full)
                            begin
                                status_next = plb_pkg::ST_FULL;
                            end
                            else if (ins_badpos)
                            begin
                                status_next = plb_pkg::ST_BADPOS;
                            end
                            else
                            begin
                                idx_next   = count_reg;
                                state_next = plb_pkg::S_INS;
                            end
                        end
                        plb_pkg::CMD_DELETE:
                        begin
                            priority if (list_empty)
                            begin
                                status_next = plb_pkg::ST_EMPTY;
                            end
                            else if (acc_badpos)
                            begin
                                status_next = plb_pkg::ST_BADPOS;
                            end
                            else
                            begin
                                // Fetch the removed entry, then shift down.
                                rd_en      = 1'b1;
                                rd_addr    = pos_m1[IDX_W-1:0];
                                idx_next   = CNT_W'(pos_m1);
                                cap_next   = 1'b1;
                                state_next = plb_pkg::S_DEL;
                            end
                        end
                        plb_pkg::CMD_SEARCH:
                        begin
                            status_next = plb_pkg::ST_NOTFND;
                            idx_next    = '0;
                            state_next  = plb_pkg::S_SRCH;
                        end
                        plb_pkg::CMD_UPDATE,
                        plb_pkg::CMD_READ:
                        begin
                            priority if (list_empty)
                            begin
                                status_next = plb_pkg::ST_EMPTY;
                            end
                            else if (acc_badpos)
                            begin
                                status_next = plb_pkg::ST_BADPOS;
                            end
                            else if (cmd_in == plb_pkg::CMD_UPDATE)
                            begin
                                wr_en   = 1'b1;
                                wr_addr = pos_m1[IDX_W-1:0];
                                wr_data = data_in;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = pos_m1[IDX_W-1:0];
                                state_next = plb_pkg::S_RD;
                            end
                        end
                        default:
                        begin
                            status_next = plb_pkg::ST_BADCMD;
                        end
                    endcase
                end
            end

            // Shift up from the tail: read entry idx-1, write it to idx next cycle.
            plb_pkg::S_INS:
            begin
                if (pend_reg)
                begin
                    wr_en = 1'b1;
                end
                if (idx_reg > CNT_W'(pos0_reg))
                begin
                    rd_en          = 1'b1;
                    rd_addr        = IDX_W'(idx_reg - CNT_W'(1));
                    pend_next      = 1'b1;
                    pend_addr_next = idx_reg[IDX_W-1:0];
                    idx_next       = idx_reg - CNT_W'(1);
                end
                else
                begin
                    pend_next  = 1'b0;
                    state_next = plb_pkg::S_INS_PUT;
                end
            end

            // Place the new entry in the gap.
            plb_pkg::S_INS_PUT:
            begin
                wr_en      = 1'b1;
                wr_addr    = pos0_reg;
                wr_data    = word_reg;
                count_next = count_reg + CNT_W'(1);
                state_next = plb_pkg::S_DONE;
            end

            // Shift down: read entry idx+1, write it to idx next cycle.
            plb_pkg::S_DEL:
            begin
                if (cap_reg)
                begin
                    dout_next = rd_data_reg;
                    cap_next  = 1'b0;
                end
                if (pend_reg)
                begin
                    wr_en = 1'b1;
                end
                if (idx_inc < (CNT_W + 1)'(count_reg))
                begin
                    rd_en          = 1'b1;
                    rd_addr        = idx_inc[IDX_W-1:0];
                    pend_next      = 1'b1;
                    pend_addr_next = idx_reg[IDX_W-1:0];
                    idx_next       = idx_inc[CNT_W-1:0];
                end
                else
                begin
                    pend_next  = 1'b0;
                    count_next = count_reg - CNT_W'(1);
                    state_next = plb_pkg::S_DONE;
                end
            end

            // Linear search: compare the entry read last cycle, fetch the next.
            plb_pkg::S_SRCH:
            begin
                priority if (pend_reg && (rd_data_reg == word_reg))
                begin
                    status_next = plb_pkg::ST_OK;
                    found_next  = found_sum[plb_pkg::POS_W-1:0];
                    pend_next   = 1'b0;
                    state_next  = plb_pkg::S_DONE;
                end
                else if (idx_reg < count_reg)
                begin
                    rd_en          = 1'b1;
                    pend_next      = 1'b1;
                    pend_addr_next = idx_reg[IDX_W-1:0];
                    idx_next       = idx_inc[CNT_W-1:0];
                end
                else
                begin
                    pend_next  = 1'b0;
                    state_next = plb_pkg::S_DONE;
                end
            end

            plb_pkg::S_RD:
            begin
                dout_next  = rd_data_reg;
                state_next = plb_pkg::S_DONE;
            end

            // Load the result word once the output register is free.
            plb_pkg::S_DONE:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = {5'b0, plb_pkg::COUNT_W'(count_reg), dout_reg,
                                    found_reg, status_reg};
                    state_next   = plb_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = plb_pkg::S_IDLE;
            end
        endcase
    end

`ifndef ASSERT_OFF
    // A shift never reads the entry it is writing in the same cycle.
    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && rd_en) |-> (wr_addr != rd_addr))
        else $error("memory read and write hit the same entry");

    // The count never exceeds the list capacity.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_CNT)
        else $error("entry count above capacity");

    // The count only moves on acceptance, at insert placement or at delete end.
    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != plb_pkg::S_IDLE && state_reg != plb_pkg::S_INS_PUT &&
         state_reg != plb_pkg::S_DEL) |=> $stable(count_reg))
        else $error("entry count changed outside a list update");

    // Every write lands inside the list or at the slot just past its end.
    a_write_in_list: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (CNT_W'(wr_addr) <= count_reg))
        else $error("memory write beyond the list");

    // Finishing a command always presents a result word.
    a_result_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == plb_pkg::S_DONE && (!m_valid_reg || m_tready)) |=> m_valid_reg)
        else $error("finished command produced no result word");
`endif

endmodule

`default_nettype wire
